// ----- design/ckrop_pkg.sv -----
// Package for the color-keyed raster operation core.
// Holds register indexes, raster operation codes and shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ckrop_pkg;

  localparam int unsigned PixW  = 24;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned RopW  = 4;
  localparam int unsigned CfgAw = 3;

  // Configuration register indexes
  localparam logic [CfgAw-1:0] REG_PIXEL_MODE  = 3'd0;
  localparam logic [CfgAw-1:0] REG_KEY_COLOR   = 3'd1;
  localparam logic [CfgAw-1:0] REG_KEY_PRESENT = 3'd2;
  localparam logic [CfgAw-1:0] REG_FORE_ROP    = 3'd3;
  localparam logic [CfgAw-1:0] REG_BACK_ROP    = 3'd4;
  localparam logic [CfgAw-1:0] REG_FORE_COLOR  = 3'd5;
  localparam logic [CfgAw-1:0] REG_BACK_COLOR  = 3'd6;

  // Pixel modes
  localparam logic MODE_RGB   = 1'b0;
  localparam logic MODE_INDEX = 1'b1;

  // Raster operation codes (d = pixel, c = operand)
  typedef enum logic [RopW-1:0] {
    ROP_NOP       = 4'd0,
    ROP_COPY      = 4'd1,
    ROP_XOR       = 4'd2,
    ROP_AND       = 4'd3,
    ROP_OR        = 4'd4,
    ROP_NOT_COPY  = 4'd5,
    ROP_INVERT    = 4'd6,
    ROP_BLACKNESS = 4'd7,
    ROP_NDEST_AND = 4'd8,
    ROP_NDEST_OR  = 4'd9,
    ROP_WHITENESS = 4'd10,
    ROP_NSRC_AND  = 4'd11,
    ROP_NSRC_OR   = 4'd12,
    ROP_NOT_XOR   = 4'd13,
    ROP_NAND      = 4'd14,
    ROP_NOR       = 4'd15
  } rop_t;

  // Live configuration, register file to datapath
  typedef struct packed {
    logic            pixel_mode;
    logic [PixW-1:0] key_color;
    logic            key_present;
    rop_t            fore_rop;
    rop_t            back_rop;
    logic [PixW-1:0] fore_color;
    logic [PixW-1:0] back_color;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            matched;
  } result_t;

endpackage

`default_nettype wire

// ----- design/ckrop_cfg_regs.sv -----
// Configuration register file for the color-keyed raster operation core.
// Depends on ckrop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ckrop_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [ckrop_pkg::CfgAw-1:0] cfg_index,
  input  wire logic [ckrop_pkg::PixW-1:0]  cfg_wdata,
  output ckrop_pkg::cfg_t                  cfg
);

  ckrop_pkg::cfg_t cfg_r;

  // Write decode; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_mode  <= ckrop_pkg::MODE_RGB;
      cfg_r.key_color   <= '0;
      cfg_r.key_present <= 1'b1;
      cfg_r.fore_rop    <= ckrop_pkg::ROP_NOP;
      cfg_r.back_rop    <= ckrop_pkg::ROP_NOP;
      cfg_r.fore_color  <= '0;
      cfg_r.back_color  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ckrop_pkg::REG_PIXEL_MODE:  cfg_r.pixel_mode  <= cfg_wdata[0];
        ckrop_pkg::REG_KEY_COLOR:   cfg_r.key_color   <= cfg_wdata;
        ckrop_pkg::REG_KEY_PRESENT: cfg_r.key_present <= cfg_wdata[0];
        ckrop_pkg::REG_FORE_ROP:
          cfg_r.fore_rop <= ckrop_pkg::rop_t'(cfg_wdata[ckrop_pkg::RopW-1:0]);
        ckrop_pkg::REG_BACK_ROP:
          cfg_r.back_rop <= ckrop_pkg::rop_t'(cfg_wdata[ckrop_pkg::RopW-1:0]);
        ckrop_pkg::REG_FORE_COLOR:  cfg_r.fore_color  <= cfg_wdata;
        ckrop_pkg::REG_BACK_COLOR:  cfg_r.back_color  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- design/ckrop_rop.sv -----
// Key compare and raster operation, purely combinational.
// Depends on ckrop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ckrop_rop (
  input  wire logic [ckrop_pkg::PixW-1:0] pixel,
  input  wire ckrop_pkg::cfg_t            cfg,
  output ckrop_pkg::result_t              res
);

  localparam logic [ckrop_pkg::PixW-1:0] IdxMask =
    {{(ckrop_pkg::PixW-ckrop_pkg::IdxW){1'b0}}, {ckrop_pkg::IdxW{1'b1}}};

  logic [ckrop_pkg::PixW-1:0] mask;
  logic [ckrop_pkg::PixW-1:0] d;
  logic [ckrop_pkg::PixW-1:0] c;
  logic [ckrop_pkg::PixW-1:0] blk;
  logic [ckrop_pkg::PixW-1:0] wht;
  logic [ckrop_pkg::PixW-1:0] r;
  logic                       match;
  ckrop_pkg::rop_t            op;

  // Mode masking and key compare; key_present only counts in index mode
  always_comb begin
    if (cfg.pixel_mode == ckrop_pkg::MODE_INDEX) begin
      mask  = IdxMask;
      match = cfg.key_present &&
              (pixel[ckrop_pkg::IdxW-1:0] == cfg.key_color[ckrop_pkg::IdxW-1:0]);
    end else begin
      mask  = '1;
      match = (pixel == cfg.key_color);
    end
    d  = pixel & mask;
    op = match ? cfg.fore_rop : cfg.back_rop;
    c  = (match ? cfg.fore_color : cfg.back_color) & mask;
    // Index mode: black and white come from the operand's palette index
    if (cfg.pixel_mode == ckrop_pkg::MODE_INDEX) begin
      blk = c;
      wht = c;
    end else begin
      blk = '0;
      wht = '1;
    end
  end

  // Operation select
  always_comb begin
    case (op)
      ckrop_pkg::ROP_NOP:       r = d;
      ckrop_pkg::ROP_COPY:      r = c;
      ckrop_pkg::ROP_XOR:       r = d ^ c;
      ckrop_pkg::ROP_AND:       r = d & c;
      ckrop_pkg::ROP_OR:        r = d | c;
      ckrop_pkg::ROP_NOT_COPY:  r = ~c;
      ckrop_pkg::ROP_INVERT:    r = ~d;
      ckrop_pkg::ROP_BLACKNESS: r = blk;
      ckrop_pkg::ROP_NDEST_AND: r = ~d & c;
      ckrop_pkg::ROP_NDEST_OR:  r = ~d | c;
      ckrop_pkg::ROP_WHITENESS: r = wht;
      ckrop_pkg::ROP_NSRC_AND:  r = d & ~c;
      ckrop_pkg::ROP_NSRC_OR:   r = d | ~c;
      ckrop_pkg::ROP_NOT_XOR:   r = d ^ ~c;
      ckrop_pkg::ROP_NAND:      r = ~(d & c);
      default:                  r = ~(d | c);
    endcase
  end

  // Result beat: masked pixel, then match flag
  assign res = {r & mask, match};

endmodule

`default_nettype wire

// ----- design/color_keyed_raster_op_core.sv -----
// Top level of the color-keyed raster operation core: input register,
// raster datapath, result register. Depends on ckrop_pkg, ckrop_cfg_regs, ckrop_rop.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------
//   in      | in        | in_valid / in_ready  | in_pixel_in[23:0]
//   out     | out       | out_valid / out_ready| out_pixel_out, out_key_matched
//   cfg     | in        | cfg_we (no wait)     | cfg_index[2:0], cfg_wdata[23:0]
//
// One pixel per clock sustained while the output is not stalled. An accepted
// beat moves from the input register into the result register, where it raises
// out_valid and waits for the output handshake.
// Synchronous active-low reset empties both stages and loads register defaults.
// A stalled output holds its beat; in_ready stays high while the input register
// is empty or can move on (result register empty or drained that cycle).
`timescale 1ns / 1ps
`default_nettype none

module color_keyed_raster_op_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ckrop_pkg::PixW-1:0]  in_pixel_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ckrop_pkg::PixW-1:0]       out_pixel_out,
  output logic                             out_key_matched,
  input  wire logic                        cfg_we,
  input  wire logic [ckrop_pkg::CfgAw-1:0] cfg_index,
  input  wire logic [ckrop_pkg::PixW-1:0]  cfg_wdata
);

  ckrop_pkg::cfg_t            cfg;
  ckrop_pkg::result_t         res;
  ckrop_pkg::result_t         res_r;
  logic [ckrop_pkg::PixW-1:0] pix_r;
  logic                       pix_vld_r;
  logic                       res_vld_r;
  logic                       res_take;
  logic                       pix_take;

  ckrop_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ckrop_rop u_rop (
    .pixel (pix_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Stage advance
  assign res_take = !res_vld_r || out_ready;
  assign in_ready = !pix_vld_r || res_take;
  assign pix_take = in_valid && in_ready;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (in_ready) pix_vld_r <= in_valid;
      if (res_take) res_vld_r <= pix_vld_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pix_take) pix_r <= in_pixel_in;
    if (res_take && pix_vld_r) res_r <= res;
  end

  assign out_valid       = res_vld_r;
  assign out_pixel_out   = res_r.pixel;
  assign out_key_matched = res_r.matched;

endmodule

`default_nettype wire
